// ===== hdl/hcbp_pkg.sv =====
// Shared types and constants for the prefix-code bit packer.
// Used by the front end, the queue, the back end and the top level.
`default_nettype none
package hcbp_pkg;

    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int SYM_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;
    localparam int Q_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    // Input command codes
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // One classified request passed from front to back
    typedef struct packed {
        logic              is_flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } entry_t;

endpackage
`default_nettype wire

// ===== hdl/hcbp_front.sv =====
// Front end: accepts requests, owns the code and length tables, classifies.
// Depends on hcbp_pkg.
`default_nettype none
module hcbp_front #(
    parameter int SYMBOLS = 256,
    parameter int LEN_CAP = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_cmd,
    input  wire logic [hcbp_pkg::SYM_W-1:0]   s_symbol,
    input  wire logic [hcbp_pkg::CODE_W-1:0]  s_code_word,
    input  wire logic [hcbp_pkg::LEN_W-1:0]   s_code_length,
    output logic                              q_valid,
    input  wire logic                         q_ready,
    output hcbp_pkg::entry_t                  q_entry
);

    localparam int IDX_W = $clog2(SYMBOLS);

    logic [LEN_CAP-1:0]            code_mem [SYMBOLS];
    logic [hcbp_pkg::LEN_W-1:0]    len_mem  [SYMBOLS];
    logic [SYMBOLS-1:0]            len_valid_reg;

    logic [LEN_CAP-1:0]            code_rd_reg;
    logic [hcbp_pkg::LEN_W-1:0]    len_rd_reg;
    logic                          lv_rd_reg;
    logic                          oob_reg;
    logic                          flush_reg;
    logic                          pend_valid_reg;
    logic                          pend_valid_next;

    logic                          accept;
    logic                          in_range;
    logic [IDX_W-1:0]              idx;
    logic [hcbp_pkg::LEN_W-1:0]    len_clamped;
    hcbp_pkg::cmd_t                cmd;

    assign cmd      = hcbp_pkg::cmd_t'(s_cmd);
    assign idx      = s_symbol[IDX_W-1:0];
    assign in_range = {1'b0, s_symbol} < (hcbp_pkg::SYM_W+1)'(SYMBOLS);
    assign s_ready  = !pend_valid_reg || q_ready;
    assign accept   = s_valid && s_ready;

    // Saturate overlong code lengths
    assign len_clamped = (s_code_length > hcbp_pkg::LEN_W'(LEN_CAP))
                       ? hcbp_pkg::LEN_W'(LEN_CAP) : s_code_length;

    // Write table entries on load
    always_ff @(posedge aclk) begin
        if (accept && cmd == hcbp_pkg::CMD_LOAD && in_range) begin
            code_mem[idx] <= s_code_word[LEN_CAP-1:0];
            len_mem[idx]  <= len_clamped;
        end
    end

    // Mark loaded lengths
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_valid_reg <= '0;
        end else if (accept && cmd == hcbp_pkg::CMD_LOAD && in_range) begin
            len_valid_reg[idx] <= 1'b1;
        end
    end

    // Read tables at accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            code_rd_reg <= code_mem[idx];
            len_rd_reg  <= len_mem[idx];
            lv_rd_reg   <= len_valid_reg[idx];
            oob_reg     <= !in_range;
            flush_reg   <= (cmd == hcbp_pkg::CMD_FLUSH);
        end
    end

    // Hold a classified request until the queue takes it
    always_comb begin
        pend_valid_next = pend_valid_reg && !q_ready;
        if (accept) begin
            pend_valid_next = (cmd == hcbp_pkg::CMD_ENCODE) || (cmd == hcbp_pkg::CMD_FLUSH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Drop the length of unloaded or out-of-range symbols
    always_comb begin
        q_entry          = '0;
        q_entry.is_flush = flush_reg;
        q_entry.code     = hcbp_pkg::CODE_W'(code_rd_reg);
        if (!flush_reg && !oob_reg && lv_rd_reg) begin
            q_entry.len = len_rd_reg;
        end
    end

    assign q_valid = pend_valid_reg;

endmodule
`default_nettype wire

// ===== hdl/hcbp_queue.sv =====
// Two-entry request queue between the front and back ends.
// Depends on hcbp_pkg.
`default_nettype none
module hcbp_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire hcbp_pkg::entry_t in_entry,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output hcbp_pkg::entry_t      out_entry
);

    localparam int PTR_W = $clog2(hcbp_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(hcbp_pkg::Q_DEPTH + 1);

    hcbp_pkg::entry_t   slot_reg [hcbp_pkg::Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic               push;
    logic               pop;

    assign in_ready  = fill_reg != CNT_W'(hcbp_pkg::Q_DEPTH);
    assign out_valid = fill_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_entry = slot_reg[rd_ptr_reg];

    // Store incoming request
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/hcbp_back.sv =====
// Back end: bit accumulator, byte emitter, saturating counters, output register.
// Depends on hcbp_pkg.
`default_nettype none
module hcbp_back #(
    parameter int LEN_CAP = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire hcbp_pkg::entry_t              q_entry,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]        m_out_byte,
    output logic                               m_byte_valid,
    output logic [hcbp_pkg::COUNT_W-1:0]       m_total_bits,
    output logic [hcbp_pkg::COUNT_W-1:0]       m_symbols_seen,
    output logic                               m_last
);

    localparam int ACC_W = LEN_CAP + 7;
    localparam int CNT_W = $clog2(ACC_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [hcbp_pkg::COUNT_W-1:0]  bits_reg, bits_next;
    logic [hcbp_pkg::COUNT_W-1:0]  syms_reg, syms_next;

    logic                          m_valid_reg, m_valid_next;
    logic [hcbp_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic                          bvalid_reg, bvalid_next;
    logic [hcbp_pkg::COUNT_W-1:0]  tb_reg, tb_next;
    logic [hcbp_pkg::COUNT_W-1:0]  ss_reg, ss_next;
    logic                          last_reg, last_next;

    logic                          out_free;
    logic                          pop;
    logic [ACC_W-1:0]              code_mask;
    logic [ACC_W-1:0]              acc_app;
    logic [CNT_W-1:0]              cnt_app;
    logic [ACC_W-1:0]              acc_sh;
    logic [CNT_W-1:0]              cnt_rem;
    logic [hcbp_pkg::BYTE_W-1:0]   flush_byte;
    logic [hcbp_pkg::COUNT_W:0]    bits_sum;
    logic [hcbp_pkg::COUNT_W:0]    syms_sum;

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == ST_IDLE) && (!q_entry.is_flush || out_free);
    assign pop      = q_valid && q_ready;

    // Append the code bits below the pending bits
    assign code_mask = (ACC_W'(1) << q_entry.len) - ACC_W'(1);
    assign acc_app   = (acc_reg << q_entry.len)
                     | (ACC_W'(q_entry.code[LEN_CAP-1:0]) & code_mask);
    assign cnt_app   = cnt_reg + CNT_W'(q_entry.len);

    // Top complete byte sits just below the count
    assign cnt_rem = cnt_reg - CNT_W'(8);
    assign acc_sh  = acc_reg >> cnt_rem;

    // Left-justify the leftover bits, zero padded
    assign flush_byte = {acc_reg[6:0], 1'b0} << (3'd7 - cnt_reg[2:0]);

    assign bits_sum = {1'b0, bits_reg} + (hcbp_pkg::COUNT_W+1)'(q_entry.len);
    assign syms_sum = {1'b0, syms_reg} + (hcbp_pkg::COUNT_W+1)'(1);

    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        bits_next    = bits_reg;
        syms_next    = syms_reg;
        m_valid_next = m_valid_reg && !m_ready;
        byte_next    = byte_reg;
        bvalid_next  = bvalid_reg;
        tb_next      = tb_reg;
        ss_next      = ss_reg;
        last_next    = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop && q_entry.is_flush) begin
                    m_valid_next = 1'b1;
                    bvalid_next  = cnt_reg != '0;
                    byte_next    = (cnt_reg != '0) ? flush_byte : '0;
                    tb_next      = bits_reg;
                    ss_next      = syms_reg;
                    last_next    = 1'b1;
                    cnt_next     = '0;
                    acc_next     = '0;
                end else if (pop) begin
                    acc_next  = acc_app;
                    cnt_next  = cnt_app;
                    bits_next = bits_sum[hcbp_pkg::COUNT_W]
                              ? hcbp_pkg::COUNT_SAT : bits_sum[hcbp_pkg::COUNT_W-1:0];
                    syms_next = syms_sum[hcbp_pkg::COUNT_W]
                              ? hcbp_pkg::COUNT_SAT : syms_sum[hcbp_pkg::COUNT_W-1:0];
                    if (cnt_app >= CNT_W'(8)) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    bvalid_next  = 1'b1;
                    byte_next    = acc_sh[7:0];
                    tb_next      = '0;
                    ss_next      = '0;
                    last_next    = cnt_rem < CNT_W'(8);
                    cnt_next     = cnt_rem;
                    if (cnt_rem < CNT_W'(8)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            bits_reg    <= '0;
            syms_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            bits_reg    <= bits_next;
            syms_reg    <= syms_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        tb_reg     <= tb_next;
        ss_reg     <= ss_next;
        last_reg   <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_byte_valid   = bvalid_reg;
    assign m_total_bits   = tb_reg;
    assign m_symbols_seen = ss_reg;
    assign m_last         = last_reg;

    // Idle only with a partial byte pending
    a_idle_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> cnt_reg < CNT_W'(8))
        else $error("pending count holds a complete byte while idle");

    // Emitting only with a complete byte available
    a_emit_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> cnt_reg >= CNT_W'(8))
        else $error("emit state without a complete byte");

    // An empty byte only comes from a flush, which always closes the request
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !bvalid_reg |-> last_reg)
        else $error("empty byte result without last");

    // No queue pop while bytes remain to be emitted
    a_no_pop_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> !q_ready)
        else $error("queue popped during byte emission");

endmodule
`default_nettype wire

// ===== hdl/huffman_code_bit_packer_top.sv =====
// Top level of the prefix-code bit packer: front end, request queue, back end.
// Depends on hcbp_pkg, hcbp_front, hcbp_queue and hcbp_back.
//
// Bytes are packed with a loaded prefix-code table. A load request (cmd 0)
// writes one symbol's code and length and gives no result; an encode request
// (cmd 1) appends the symbol's code, and each completed byte comes out most
// significant bit first; a flush (cmd 2) gives one result with the zero-padded
// leftover bits plus the saturating bit and symbol counts. The front end
// accepts one request per cycle while the two-entry queue has room. The back
// end appends an encode's code to the bit accumulator, then emits each
// completed byte (0 to 4) while the output is free, and takes no new request
// until the single byte emitter behind the accumulator has sent them all. A
// flush waits for a free output. The length table clears at reset; code entries
// hold nothing until loaded, and an unloaded symbol encodes as zero bits.
`default_nettype none
module huffman_code_bit_packer_top #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOLS      = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_cmd,
    input  wire logic [hcbp_pkg::SYM_W-1:0]    s_symbol,
    input  wire logic [hcbp_pkg::CODE_W-1:0]   s_code_word,
    input  wire logic [hcbp_pkg::LEN_W-1:0]    s_code_length,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [hcbp_pkg::BYTE_W-1:0]        m_out_byte,
    output logic                               m_byte_valid,
    output logic [hcbp_pkg::COUNT_W-1:0]       m_total_bits,
    output logic [hcbp_pkg::COUNT_W-1:0]       m_symbols_seen,
    output logic                               m_last
);

    localparam int LEN_CAP = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : hcbp_pkg::CODE_W;

    logic             fq_valid;
    logic             fq_ready;
    hcbp_pkg::entry_t fq_entry;
    logic             qb_valid;
    logic             qb_ready;
    hcbp_pkg::entry_t qb_entry;

    hcbp_front #(
        .SYMBOLS (SYMBOLS),
        .LEN_CAP (LEN_CAP)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_symbol      (s_symbol),
        .s_code_word   (s_code_word),
        .s_code_length (s_code_length),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_entry       (fq_entry)
    );

    hcbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_entry  (fq_entry),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_entry (qb_entry)
    );

    hcbp_back #(
        .LEN_CAP (LEN_CAP)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (qb_valid),
        .q_ready        (qb_ready),
        .q_entry        (qb_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_total_bits   (m_total_bits),
        .m_symbols_seen (m_symbols_seen),
        .m_last         (m_last)
    );

endmodule
`default_nettype wire
